// ===== design/assert_macros.svh =====
// Assertion macros for the chunked body decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true at an edge implies consequent at the same edge.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Antecedent true at an edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== design/hcbd_pkg.sv =====
// Types, codes and byte classifiers for the chunked body decoder.
package hcbd_pkg;

	// Input item: command plus received byte
	typedef struct packed {
		logic       cmd;
		logic [7:0] in_byte;
	} in_item_t;

	// Result item: kind plus payload byte
	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_data;
	} out_item_t;

	// Result of one decode step handed to the output register
	typedef struct packed {
		logic      valid;
		out_item_t item;
	} core_res_t;

	localparam logic       CMD_BYTE    = 1'b0;
	localparam logic       CMD_RESTART = 1'b1;

	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_COMPLETE = 2'd1;
	localparam logic [1:0] KIND_EMPTY    = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	localparam int CHUNK_W = 32;
	localparam int HEX_W   = 4;

	// Space, TAB, VT, FF and CR count as leading blanks
	function automatic logic is_blank(input logic [7:0] b);
		return (b inside {8'h20, 8'h09, 8'h0B, 8'h0C, CH_CR});
	endfunction

	// Returns {is_hex, value}
	function automatic logic [HEX_W:0] hex_decode(input logic [7:0] b);
		logic [HEX_W:0] r;
		r = '0;
		if (b inside {[8'h30:8'h39]}) begin
			r = {1'b1, b[3:0]};
		end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			r = {1'b1, HEX_W'(b[2:0] + 3'd1) + HEX_W'(4'd8) + HEX_W'(4'd0)};
		end
		return r;
	endfunction

endpackage

// ===== design/http_chunked_body_decoder_top.sv =====
// Chunked transfer body decoder: one body byte in, at most one result out.
// The decoder strips HTTP/1.1 chunked framing from a byte stream and takes one
// item per clock cycle when the output side keeps up. An item goes from the
// input register through the framing logic into the result register, which
// loads its result once free and holds it until taken. Items that give no
// result leave the input register without waiting for the output side. The
// rate is set by the single framing state update per byte, one per cycle
// while no result is held back.
// A restart item clears all framing state and gives no result.
module http_chunked_body_decoder_top #(
	parameter int MAX_SIZE_DIGITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hcbd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output hcbd_pkg::out_item_t out_item
);
	import hcbd_pkg::*;
	`include "assert_macros.svh"

	logic      valid_s1;
	in_item_t  item_s1;
	core_res_t res;
	logic      can_load;
	logic      step;
	logic      push;

	// Item moves on unless it has a result and the output register is not free
	assign step = valid_s1 && (!res.valid || can_load);
	assign push = step && res.valid;

	hcbd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.step     (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hcbd_core #(
		.MAX_SIZE_DIGITS (MAX_SIZE_DIGITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res)
	);

	hcbd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (res.item),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// A result is only loaded into a free output register
	`ASSERT_SAME(a_push_free, clk, arst_n, push, can_load)
	// Non-payload results carry a zero data byte
	`ASSERT_SAME(a_data_zero, clk, arst_n, out_valid && out_item.out_kind != KIND_PAYLOAD, out_item.out_data == 8'd0)
	// Input side stalls only behind a held item
	`ASSERT_SAME(a_stall_held, clk, arst_n, !in_ready, valid_s1 && res.valid && !can_load)
	// A pushed result is visible on the next cycle
	`ASSERT_NEXT(a_push_shows, clk, arst_n, push, out_valid)

endmodule

// ===== design/hcbd_in_stage.sv =====
// Input register stage of the chunked body decoder.
module hcbd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hcbd_pkg::in_item_t in_item,
	input  logic              step,
	output logic              valid_s1,
	output hcbd_pkg::in_item_t item_s1
);
	import hcbd_pkg::*;

	// Stage accepts when empty or when its item moves on this cycle
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload register, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== design/hcbd_core.sv =====
// Framing state and per-byte decode logic of the chunked body decoder.
module hcbd_core #(
	parameter int MAX_SIZE_DIGITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  hcbd_pkg::in_item_t item,
	output hcbd_pkg::core_res_t res
);
	import hcbd_pkg::*;

	localparam int DCW = $clog2(MAX_SIZE_DIGITS + 1);

	typedef enum logic [4:0] {
		PH_SIZE    = 5'b00001,
		PH_DATA    = 5'b00010,
		PH_SKIP    = 5'b00100,
		PH_TRAILER = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		SCAN_BLANK  = 3'b001,
		SCAN_DIGITS = 3'b010,
		SCAN_STOP   = 3'b100
	} scan_t;

	phase_t             phase_q, phase_d;
	scan_t              scan_q, scan_d;
	logic [CHUNK_W-1:0] chunk_q, chunk_d;
	logic [CHUNK_W-1:0] left_q, left_d;
	logic [1:0]         skip_q, skip_d;
	logic [1:0]         lchars_q, lchars_d;
	logic               first_cr_q, first_cr_d;
	logic [DCW-1:0]     digits_q, digits_d;
	logic               seen_q, seen_d;

	logic [7:0]         b;
	logic [HEX_W:0]     hx;
	logic               line_empty;
	logic [CHUNK_W-1:0] left_dec;
	logic [1:0]         skip_dec;

	assign b          = item.in_byte;
	assign hx         = hex_decode(b);
	assign line_empty = (lchars_q == 2'd0) || (lchars_q == 2'd1 && first_cr_q);
	assign left_dec   = (left_q != '0) ? left_q - CHUNK_W'(1) : left_q;
	assign skip_dec   = (skip_q != 2'd0) ? skip_q - 2'd1 : skip_q;

	// Next state and result for the item at the input register
	always_comb begin
		phase_d    = phase_q;
		scan_d     = scan_q;
		chunk_d    = chunk_q;
		left_d     = left_q;
		skip_d     = skip_q;
		lchars_d   = lchars_q;
		first_cr_d = first_cr_q;
		digits_d   = digits_q;
		seen_d     = seen_q;
		res        = '0;

		if (item.cmd == CMD_RESTART) begin
			phase_d    = PH_SIZE;
			scan_d     = SCAN_BLANK;
			chunk_d    = '0;
			left_d     = '0;
			skip_d     = 2'd0;
			lchars_d   = 2'd0;
			first_cr_d = 1'b0;
			digits_d   = '0;
			seen_d     = 1'b0;
		end else begin
			case (phase_q)
				PH_SIZE: begin
					if (b == CH_LF) begin
						// End of size line: clear line state, pick next phase
						scan_d     = SCAN_BLANK;
						chunk_d    = '0;
						lchars_d   = 2'd0;
						first_cr_d = 1'b0;
						digits_d   = '0;
						if (!line_empty) begin
							if (chunk_q == '0) begin
								phase_d = PH_TRAILER;
							end else begin
								left_d  = chunk_q;
								phase_d = PH_DATA;
							end
						end
					end else begin
						if (lchars_q == 2'd0) begin
							first_cr_d = (b == CH_CR);
						end
						if (lchars_q != 2'd2) begin
							lchars_d = lchars_q + 2'd1;
						end
						if (scan_q != SCAN_STOP) begin
							if (hx[HEX_W]) begin
								scan_d = SCAN_DIGITS;
								if (digits_q == DCW'(MAX_SIZE_DIGITS)) begin
									// One digit too many ends the body
									phase_d            = PH_DONE;
									res.valid          = 1'b1;
									res.item.out_kind  = KIND_OVERFLOW;
								end else begin
									digits_d = digits_q + DCW'(1);
									chunk_d  = {chunk_q[CHUNK_W-HEX_W-1:0], hx[HEX_W-1:0]};
								end
							end else if (!(scan_q == SCAN_BLANK && is_blank(b))) begin
								scan_d = SCAN_STOP;
							end
						end
					end
				end
				PH_DATA: begin
					seen_d            = 1'b1;
					left_d            = left_dec;
					res.valid         = 1'b1;
					res.item.out_kind = KIND_PAYLOAD;
					res.item.out_data = b;
					if (left_dec == '0) begin
						skip_d  = 2'd2;
						phase_d = PH_SKIP;
					end
				end
				PH_SKIP: begin
					// Drop the two bytes after chunk data
					skip_d = skip_dec;
					if (skip_dec == 2'd0) begin
						phase_d = PH_SIZE;
					end
				end
				PH_TRAILER: begin
					if (b == CH_LF) begin
						scan_d     = SCAN_BLANK;
						chunk_d    = '0;
						lchars_d   = 2'd0;
						first_cr_d = 1'b0;
						digits_d   = '0;
						if (line_empty) begin
							phase_d           = PH_DONE;
							res.valid         = 1'b1;
							res.item.out_kind = seen_q ? KIND_COMPLETE : KIND_EMPTY;
						end
					end else begin
						if (lchars_q == 2'd0) begin
							first_cr_d = (b == CH_CR);
						end
						if (lchars_q != 2'd2) begin
							lchars_d = lchars_q + 2'd1;
						end
					end
				end
				PH_DONE: begin
				end
				default: begin
					phase_d = PH_SIZE;
				end
			endcase
		end
	end

	// State registers, updated when the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SIZE;
			scan_q     <= SCAN_BLANK;
			chunk_q    <= '0;
			left_q     <= '0;
			skip_q     <= 2'd0;
			lchars_q   <= 2'd0;
			first_cr_q <= 1'b0;
			digits_q   <= '0;
			seen_q     <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			scan_q     <= scan_d;
			chunk_q    <= chunk_d;
			left_q     <= left_d;
			skip_q     <= skip_d;
			lchars_q   <= lchars_d;
			first_cr_q <= first_cr_d;
			digits_q   <= digits_d;
			seen_q     <= seen_d;
		end
	end

endmodule

// ===== design/hcbd_out_reg.sv =====
// Result register of the chunked body decoder.
module hcbd_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hcbd_pkg::out_item_t push_item,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output hcbd_pkg::out_item_t out_item
);
	import hcbd_pkg::*;

	// Free when empty or when the held item is taken this cycle
	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && can_load) begin
			out_item <= push_item;
		end
	end

endmodule
